// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Depends on nothing; the checker supplies signals named clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds in every cycle outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ptdt_pkg.sv =====
// Package for the periodic task dispatch table: codes, sizes and the structs
// passed between the top level and its slot cells. Depends on nothing.
package ptdt_pkg;

  localparam int PTDT_SLOTS = 16;
  localparam int MAX_OUT    = 16;
  localparam int CNT_W      = $clog2(MAX_OUT + 1);
  localparam int SLOT_W     = 4;
  localparam int FUNC_W     = 2;
  localparam int KIND_W     = 3;
  localparam int PERIOD_W   = 32;
  localparam int TIME_W     = 48;
  localparam int MINP_W     = 16;

  localparam logic [MINP_W-1:0] MIN_PERIOD_RESET = 16'd100;
  localparam logic [TIME_W-1:0] TIME_MAX         = {TIME_W{1'b1}};

  localparam logic [FUNC_W-1:0] FN_ATTACH = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DETACH = 2'd1;
  localparam logic [FUNC_W-1:0] FN_TICK   = 2'd2;

  localparam logic [KIND_W-1:0] K_ATTACHED = 3'd0;
  localparam logic [KIND_W-1:0] K_FULL     = 3'd1;
  localparam logic [KIND_W-1:0] K_DETACHED = 3'd2;
  localparam logic [KIND_W-1:0] K_DUE      = 3'd3;
  localparam logic [KIND_W-1:0] K_IDLE     = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]   op;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   now;
  } ptdt_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             claimed;
    logic [CNT_W-1:0] cnt;
  } ptdt_tok_t;

endpackage

// ===== rtl/core/periodic_task_dispatch_table.sv =====
// Top level of the periodic task dispatch table: command port, one config
// register and a chain of ptdt_cell slots. Depends on ptdt_pkg and ptdt_cell.
//
// Usage: a command word is taken at a clock edge with start high and busy low.
// in_func selects attach, detach or tick; func 3 is dropped without a result.
// Detach returns its result in the cycle after the command and busy never
// rises. Attach and tick send a token down the chain of SLOTS cells, one
// cell per cycle, so the chain length sets how long the scan lasts; busy
// stays high through ST_SCAN and ST_FINISH and the final result is registered
// on leaving ST_FINISH. A tick delivers each due slot in ascending order, one
// word per strobe on out_valid, with out_last on the final word. The receiver
// cannot stall; each word is valid for exactly one cycle.
// The minimum period is written through cfg_valid/cfg_ready, which is always
// ready; write it only while busy is low and no result is pending.
// Synchronous reset clears every slot, sets the minimum period to 100 ms and
// returns the block to idle.
module periodic_task_dispatch_table
  import ptdt_pkg::*;
#(
  parameter int SLOTS = PTDT_SLOTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [PERIOD_W-1:0] in_period_ms,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic [TIME_W-1:0]   in_now_ms,
  output logic                out_valid,
  output logic [KIND_W-1:0]   out_kind,
  output logic [SLOT_W-1:0]   out_task_slot,
  output logic                out_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MINP_W-1:0]   cfg_min_period_ms
);

  localparam int POS_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t              state_r;
  logic [MINP_W-1:0]   min_period_r;
  logic [POS_W-1:0]    pos_r;
  logic                launch_r;
  logic                pend_r;
  logic [SLOT_W-1:0]   pend_slot_r;
  logic [FUNC_W-1:0]   op_r;
  logic [PERIOD_W-1:0] per_r;
  logic [TIME_W-1:0]   now_r;
  logic                out_valid_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [SLOT_W-1:0]   out_task_slot_r;
  logic                out_last_r;
  logic                accept;
  logic [PERIOD_W-1:0] min_ext;
  logic                any_hit;
  ptdt_ctl_t           ctl;
  ptdt_tok_t           tok [SLOTS+1];
  logic [SLOTS-1:0]    hit_vec;
  logic [SLOTS-1:0]    det_vec;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign min_ext   = {{(PERIOD_W - MINP_W){1'b0}}, min_period_r};
  assign any_hit   = |hit_vec;

  assign ctl = '{op: op_r, period: per_r, now: now_r};

  assign tok[0] = '{valid: launch_r, claimed: 1'b0, cnt: '0};

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign det_vec[i] = accept && (in_func == FN_DETACH) && (int'(in_slot) == i);
    ptdt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .det_i (det_vec[i]),
      .tok_i (tok[i]),
      .tok_o (tok[i+1]),
      .hit_o (hit_vec[i])
    );
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_task_slot = out_task_slot_r;
  assign out_last      = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= MIN_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_period_r <= cfg_min_period_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      pos_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      launch_r    <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_func)
              FN_ATTACH, FN_TICK: begin
                op_r     <= in_func;
                per_r    <= (in_period_ms < min_ext) ? min_ext : in_period_ms;
                now_r    <= in_now_ms;
                launch_r <= 1'b1;
                pos_r    <= '0;
                pend_r   <= 1'b0;
                state_r  <= ST_SCAN;
              end
              FN_DETACH: begin
                out_valid_r     <= 1'b1;
                out_kind_r      <= K_DETACHED;
                out_task_slot_r <= in_slot;
                out_last_r      <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (any_hit) begin
            if (pend_r) begin
              out_valid_r     <= 1'b1;
              out_kind_r      <= K_DUE;
              out_task_slot_r <= pend_slot_r;
              out_last_r      <= 1'b0;
            end
            pend_r      <= 1'b1;
            pend_slot_r <= SLOT_W'(pos_r);
          end
          if (pos_r == POS_W'(SLOTS - 1)) begin
            state_r <= ST_FINISH;
          end else begin
            pos_r <= pos_r + 1'b1;
          end
        end
        ST_FINISH: begin
          out_valid_r <= 1'b1;
          out_last_r  <= 1'b1;
          if (pend_r) begin
            out_kind_r      <= (op_r == FN_ATTACH) ? K_ATTACHED : K_DUE;
            out_task_slot_r <= pend_slot_r;
          end else begin
            out_kind_r      <= (op_r == FN_ATTACH) ? K_FULL : K_IDLE;
            out_task_slot_r <= '0;
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/ptdt_cell.sv =====
// One slot of the dispatch table: in-use flag, period and next due time.
// A scan token passes through it once per attach or tick. Depends on ptdt_pkg.
module ptdt_cell
  import ptdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ptdt_ctl_t ctl,
  input  logic      det_i,
  input  ptdt_tok_t tok_i,
  output ptdt_tok_t tok_o,
  output logic      hit_o
);

  logic                in_use_r, in_use_nxt;
  logic [PERIOD_W-1:0] period_r;
  logic [TIME_W-1:0]   due_r, due_nxt;
  ptdt_tok_t           tok_r, tok_nxt;
  logic                claim, due_hit;
  logic [TIME_W:0]     sum;

  assign claim   = tok_i.valid && (ctl.op == FN_ATTACH) && !tok_i.claimed && !in_use_r;
  assign due_hit = tok_i.valid && (ctl.op == FN_TICK) && in_use_r && (ctl.now >= due_r) &&
                   (tok_i.cnt < CNT_W'(MAX_OUT));
  assign sum     = {1'b0, ctl.now} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, period_r};
  assign hit_o   = claim || due_hit;
  assign tok_o   = tok_r;

  always_comb begin
    in_use_nxt = in_use_r;
    due_nxt    = due_r;
    if (det_i) begin
      in_use_nxt = 1'b0;
    end else if (claim) begin
      in_use_nxt = 1'b1;
      due_nxt    = '0;
    end else if (due_hit) begin
      due_nxt = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    end
    tok_nxt         = tok_i;
    tok_nxt.claimed = tok_i.claimed || claim;
    tok_nxt.cnt     = tok_i.cnt + CNT_W'(due_hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= 1'b0;
      due_r    <= '0;
      tok_r    <= '0;
    end else begin
      in_use_r <= in_use_nxt;
      due_r    <= due_nxt;
      tok_r    <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      period_r <= ctl.period;
    end
  end

endmodule

// ===== rtl/core/ptdt_checker.sv =====
// Port-level checker for the periodic task dispatch table, bound to the top.
// Depends on ptdt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptdt_checker
  import ptdt_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic [FUNC_W-1:0]   in_func,
  input logic                out_valid,
  input logic [KIND_W-1:0]   out_kind,
  input logic [SLOT_W-1:0]   out_task_slot,
  input logic                out_last
);

  logic zero_kind;
  logic single_kind;
  logic scan_cmd;

  assign zero_kind   = out_kind inside {K_FULL, K_IDLE};
  assign single_kind = out_kind inside {K_ATTACHED, K_DETACHED, K_FULL, K_IDLE};
  assign scan_cmd    = in_func inside {FN_ATTACH, FN_TICK};

  `ASSERT_IMPL(a_zero_slot, out_valid && zero_kind, out_task_slot == '0, "Bad slot.")
  `ASSERT_IMPL(a_single_last, out_valid && single_kind, out_last, "Word not marked last.")
  `ASSERT_IMPL(a_more_pending, out_valid && !out_last, busy, "Non-final word while idle.")
  `ASSERT_NEXT(a_scan_busy, start && !busy && scan_cmd, busy && !out_valid, "Scan not started.")

endmodule

bind periodic_task_dispatch_table ptdt_checker u_ptdt_checker (.*);
